[design/ptt_pkg.sv]
// shared types and constants of the priority task table
`timescale 1ns / 1ps

package ptt_pkg;

    // field widths fixed by the item format
    localparam int ID_W        = 8;
    localparam int PRIO_IN_W   = 4;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 4;
    localparam int EXT_W       = 8;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;

    localparam logic [ID_W-1:0] ID_ZERO = 8'd0;
    localparam logic [ID_W-1:0] ID_ONE  = 8'd1;
    localparam logic [ID_W-1:0] ID_MAX  = 8'd255;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_PLACE,
        S_RESULT
    } ptt_state_t;

endpackage

[design/priority_task_table_unit.sv]
// priority task table: sorted insert with unique id allocation, and id lookup
`timescale 1ns / 1ps

// Keeps up to TABLE_DEPTH tasks ordered by descending priority, each with a
// unique nonzero 8-bit id. An input item (s_tuser = op) either inserts a task
// or looks up the slot of an id; every item gives exactly one result item.
// The block takes one item at a time: s_tready is high only while the
// sequencer is idle. A lookup goes from S_CHECK to S_RESULT, which loads
// the output register. An insert tries N id candidates in S_CHECK,
// one candidate per cycle through a single bank of equality
// comparators shared by the id search and the lookup, so N is at most
// TABLE_DEPTH + 1 (requested id taken, or zero, plus one step per
// occupied id), and then passes S_PLACE and S_RESULT. A full table goes
// from S_CHECK straight to S_RESULT. The next item is taken only once the
// sequencer is back in S_IDLE, after S_RESULT. The insert position comes
// from one priority compare across the table, and the shift-down of later
// entries happens in the single S_PLACE state. Results wait in an output register, so
// a stalled m_tready delays only the next item's result, not its start.
// The table stores need no clearing pass: only slots below the entry count
// are ever compared.
module priority_task_table_unit #(
    parameter int TABLE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ptt_pkg::S_TDATA_W-1:0]  s_tdata,   // priority_req[3:0], key_id[11:4]
    input  logic [ptt_pkg::S_TUSER_W-1:0]  s_tuser,   // op[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ptt_pkg::M_TDATA_W-1:0]  m_tdata,   // assigned_id[7:0], slot[11:8]
    output logic [ptt_pkg::M_TUSER_W-1:0]  m_tuser    // status[1:0]
);

    import ptt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    // sequencer and latched item
    ptt_state_t               state_reg, state_next;
    logic                     op_reg, op_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic [ID_W-1:0]          cand_reg, cand_next;

    // table contents
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ID_W-1:0]          ids_reg   [TABLE_DEPTH];
    logic [ID_W-1:0]          ids_next  [TABLE_DEPTH];
    logic [PRIORITY_BITS-1:0] prios_reg [TABLE_DEPTH];
    logic [PRIORITY_BITS-1:0] prios_next[TABLE_DEPTH];

    // pending result and output register
    logic [STATUS_W-1:0]      res_status_reg, res_status_next;
    logic [ID_W-1:0]          res_id_reg, res_id_next;
    logic [SLOT_W-1:0]        res_slot_reg, res_slot_next;
    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      out_status_reg, out_status_next;
    logic [ID_W-1:0]          out_id_reg, out_id_next;
    logic [SLOT_W-1:0]        out_slot_reg, out_slot_next;

    // shared compare bank
    logic [TABLE_DEPTH-1:0]   valid_vec;
    logic [TABLE_DEPTH-1:0]   match_vec;
    logic [TABLE_DEPTH-1:0]   ge_vec;
    logic                     any_match;
    logic                     cand_taken;
    logic [IDX_W-1:0]         match_idx;
    logic [IDX_W-1:0]         ins_pos;
    logic [ID_W-1:0]          cand_inc;
    logic [EXT_W-1:0]         prio_wide;
    logic [EXT_W-1:0]         match_ext;
    logic [EXT_W-1:0]         pos_ext;

    // per-entry compares: id against the current candidate, priority against the new one
    always_comb begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            valid_vec[k] = CNT_W'(k) < count_reg;
            match_vec[k] = valid_vec[k] && (ids_reg[k] == cand_reg);
            ge_vec[k]    = valid_vec[k] && (prio_reg <= prios_reg[k]);
        end
    end

    // ids are unique, so at most one match: an or-encode gives its index
    // the table is sorted, so ge_vec is a run of ones from slot 0; the insert
    // position is the first zero, found as the one-hot falling edge
    always_comb begin
        match_idx = '0;
        ins_pos   = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (match_vec[k]) begin
                match_idx = match_idx | IDX_W'(k);
            end
        end
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            if (ge_vec[k-1] && !ge_vec[k]) begin
                ins_pos = ins_pos | IDX_W'(k);
            end
        end
    end

    assign any_match  = |match_vec;
    assign cand_taken = (cand_reg == ID_ZERO) || any_match;
    // wrap from 255 onto 1, never onto 0
    assign cand_inc   = (cand_reg == ID_MAX) ? ID_ONE : cand_reg + ID_ONE;
    assign prio_wide  = EXT_W'(s_tdata[PRIO_IN_W-1:0]);
    assign match_ext  = EXT_W'(match_idx);
    assign pos_ext    = EXT_W'(ins_pos);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        prio_next       = prio_reg;
        cand_next       = cand_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_slot_next   = out_slot_reg;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            ids_next[k]   = ids_reg[k];
            prios_next[k] = prios_reg[k];
        end
        s_tready = 1'b0;

        // output register drains independently of the sequencer
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next    = s_tuser[0];
                    prio_next  = prio_wide[PRIORITY_BITS-1:0];
                    cand_next  = s_tdata[PRIO_IN_W +: ID_W];
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (op_reg == OP_LOOKUP) begin
                    res_status_next = any_match ? ST_OK : ST_MISSING;
                    res_id_next     = cand_reg;
                    res_slot_next   = any_match ? match_ext[SLOT_W-1:0] : '0;
                    state_next      = S_RESULT;
                end else if (count_reg == FULL_COUNT) begin
                    res_status_next = ST_FULL;
                    res_id_next     = cand_reg;
                    res_slot_next   = '0;
                    state_next      = S_RESULT;
                end else if (cand_taken) begin
                    // try the next id on the following cycle
                    cand_next = cand_inc;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                // entries at and below the insert position move down one slot
                if (ins_pos == '0) begin
                    ids_next[0]   = cand_reg;
                    prios_next[0] = prio_reg;
                end
                for (int k = 1; k < TABLE_DEPTH; k++) begin
                    if (IDX_W'(k) > ins_pos) begin
                        ids_next[k]   = ids_reg[k-1];
                        prios_next[k] = prios_reg[k-1];
                    end else if (IDX_W'(k) == ins_pos) begin
                        ids_next[k]   = cand_reg;
                        prios_next[k] = prio_reg;
                    end
                end
                count_next      = count_reg + CNT_W'(1);
                res_status_next = ST_OK;
                res_id_next     = cand_reg;
                res_slot_next   = pos_ext[SLOT_W-1:0];
                state_next      = S_RESULT;
            end
            S_RESULT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_slot_next   = res_slot_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and table storage
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        prio_reg       <= prio_next;
        cand_reg       <= cand_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_slot_reg   <= out_slot_next;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            ids_reg[k]   <= ids_next[k];
            prios_reg[k] <= prios_next[k];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_slot_reg, out_id_reg});
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    // entry count never passes the table depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("entry count above table depth");

    // placing an entry grows the table by exactly one
    a_place_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PLACE) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the table by one");

    // an id is placed only when it is nonzero and unused
    a_place_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PLACE) |-> (cand_reg != ID_ZERO && !any_match))
        else $error("placing a zero or duplicate id");

    // the candidate search never steps onto id zero
    a_search_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK && $past(state_reg) == S_CHECK) |-> (cand_reg != ID_ZERO))
        else $error("id search wrapped onto zero");

    // a finished result is not lost while the output register is still held
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && out_valid_reg && !m_tready) |=> (state_reg == S_RESULT))
        else $error("result dropped while output stalled");
`endif

endmodule
